@@ design/apf_pkg.sv @@
// apf_pkg: shared types and constants of the average pooling block.
// No dependencies.
package apf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 10;
    localparam int CFG_W    = 11;
    localparam int CFG_IW   = 3;
    localparam int NUM_W    = 13;

    localparam logic [CFG_IW-1:0] REG_KERNEL = 3'd0;
    localparam logic [CFG_IW-1:0] REG_STRIDE = 3'd1;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DEPTH  = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

@@ design/apf_in_if.sv @@
// apf_in_if: sample channel, valid/ready with one signed Q8.8 sample.
// Depends on apf_pkg.
interface apf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [apf_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ design/apf_out_if.sv @@
// apf_out_if: result channel, valid/ready with average and window position.
// Depends on apf_pkg.
interface apf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [apf_pkg::SAMPLE_W-1:0]  average;
    logic [apf_pkg::IDX_W-1:0]            out_channel;
    logic [apf_pkg::IDX_W-1:0]            out_row;
    logic [apf_pkg::IDX_W-1:0]            out_col;
    logic                                 last;

    modport source (output valid, output average, output out_channel, output out_row,
                    output out_col, output last, input ready);
    modport sink   (input valid, input average, input out_channel, input out_row,
                    input out_col, input last, output ready);
endinterface

@@ design/apf_ram.sv @@
// apf_ram: generic single-write, single-read RAM with registered read.
// Read of the address being written returns the old contents.
module apf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

@@ design/apf_cell.sv @@
// apf_cell: one column-sum cell of the window chain.
// Holds one column sum, passes it on at each shift, adds it to the window sum when active.
module apf_cell #(
    parameter int CSW = 19,
    parameter int WSW = 22
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  apf_pkg::cell_ctrl_t     ctrl,
    input  logic                    active,
    input  logic signed [CSW-1:0]   sum_in,
    output logic signed [CSW-1:0]   sum_out,
    input  logic signed [WSW-1:0]   part_in,
    output logic signed [WSW-1:0]   part_out
);

    logic signed [CSW-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sum_reg <= sum_in;
        end
    end

    assign sum_out  = sum_reg;
    assign part_out = part_in + (active ? WSW'(sum_reg) : WSW'(0));

endmodule

@@ design/apf_div.sv @@
// apf_div: serial signed divider, one quotient bit per cycle, truncates toward zero.
// Standalone; used by the top level for the division by kernel squared.
module apf_div #(
    parameter int WSW = 22,
    parameter int DVW = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [WSW-1:0]   dividend,
    input  logic [DVW-1:0]          divisor,
    output logic                    done,
    output logic signed [15:0]      quotient
);

    localparam int CNTW = $clog2(WSW + 1);

    logic [WSW-1:0]  dvd_reg, dvd_next;
    logic [DVW-1:0]  rem_reg, rem_next;
    logic [DVW-1:0]  dsr_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            neg_reg;
    logic            done_reg, done_next;
    logic [DVW:0]    trial;
    logic [WSW-1:0]  q_signed;

    assign trial = {rem_reg, dvd_reg[WSW-1]};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend[WSW-1] ? WSW'(-dividend) : WSW'(dividend);
            rem_next = '0;
            cnt_next = CNTW'(WSW);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DVW'(trial - {1'b0, dsr_reg});
                dvd_next = {dvd_reg[WSW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVW-1:0];
                dvd_next = {dvd_reg[WSW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNTW'(1);
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
            neg_reg <= dividend[WSW-1];
        end
    end

    assign q_signed = neg_reg ? WSW'(-dvd_reg) : dvd_reg;
    assign quotient = q_signed[15:0];
    assign done     = done_reg;

endmodule

@@ design/avg_pool_forward.sv @@
// avg_pool_forward: streaming 2-D average pooling, forward direction.
// Depends on apf_pkg, apf_in_if, apf_out_if, apf_ram, apf_cell, apf_div.
//
// Usage:
//  - samples: valid/ready channel, one signed Q8.8 sample per transfer, in
//    channel, row, column raster order.
//  - results: valid/ready channel, one window average per transfer with its
//    channel, output row, output column and a last flag on the tensor's end.
//  - cfg_we/cfg_index/cfg_data: register writes (kernel, stride, height,
//    width, depth); a write restarts the tensor. Write only while idle.
//  - A sample that opens no window goes through the column-sum state only. A
//    sample that closes a window adds the sum, divide and output states; the
//    serial divider in the divide state produces one quotient bit per cycle.
//  - The result sits in an output register; the next sample is taken while
//    it waits. A stalled receiver only blocks once the next result is ready.
//  - Reset loads the default registers and clears counters and column sums.
//    Line stores are not cleared: only rows already written are read.
//  - With invalid registers samples are taken and dropped.
module avg_pool_forward #(
    parameter int K_MAX = 8,
    parameter int W_MAX = 1024,
    parameter int H_MAX = 1024,
    parameter int D_MAX = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    apf_in_if.sink                        samples,
    apf_out_if.source                     results,
    input  logic                          cfg_we,
    input  logic [apf_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [apf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int LINES = (K_MAX > 1) ? K_MAX - 1 : 1;
    localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int KB    = (K_MAX > 1) ? $clog2(K_MAX) : 0;
    localparam int CSW   = 16 + KB;
    localparam int WSW   = 16 + 2 * KB;
    localparam int DVW   = 2 * KB + 1;
    localparam int CW    = $clog2(W_MAX);
    localparam int RW    = $clog2(H_MAX);
    localparam int DCW   = (D_MAX > 1) ? $clog2(D_MAX) : 1;
    localparam int NW    = apf_pkg::NUM_W;

    // configuration registers
    logic [3:0]  kernel_reg, stride_reg;
    logic [10:0] height_reg, width_reg, depth_reg;
    logic        restart;
    logic        cfg_ok;

    always_comb
    begin
        unique case (cfg_index) inside
            apf_pkg::REG_KERNEL, apf_pkg::REG_STRIDE, apf_pkg::REG_HEIGHT,
            apf_pkg::REG_WIDTH, apf_pkg::REG_DEPTH: restart = cfg_we;
            default: restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= 4'd3;
            stride_reg <= 4'd1;
            height_reg <= 11'd1024;
            width_reg  <= 11'd1024;
            depth_reg  <= 11'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apf_pkg::REG_KERNEL: kernel_reg <= cfg_data[3:0];
                apf_pkg::REG_STRIDE: stride_reg <= cfg_data[3:0];
                apf_pkg::REG_HEIGHT: height_reg <= cfg_data;
                apf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                apf_pkg::REG_DEPTH:  depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ok = (kernel_reg != 4'd0) && (NW'(kernel_reg) <= NW'(K_MAX)) &&
                    (stride_reg != 4'd0) &&
                    (height_reg != 11'd0) && (NW'(height_reg) <= NW'(H_MAX)) &&
                    (width_reg != 11'd0) && (NW'(width_reg) <= NW'(W_MAX)) &&
                    (depth_reg != 11'd0) && (NW'(depth_reg) <= NW'(D_MAX));

    // position counters and stride phases
    apf_pkg::state_t state_reg, state_next;
    logic            accept, take;
    logic [CW-1:0]   col_reg, col_next, ocol_reg, ocol_next;
    logic [RW-1:0]   row_reg, row_next, orow_reg, orow_next;
    logic [DCW-1:0]  chan_reg, chan_next;
    logic [LW-1:0]   wline_reg, wline_next;
    logic [3:0]      cphase_reg, cphase_next, rphase_reg, rphase_next;
    logic [NW-1:0]   c_p1, r_p1, d_p1;
    logic            full_rows, emit, is_last;

    assign accept = samples.valid && samples.ready;
    assign take   = accept && cfg_ok;
    assign c_p1   = NW'(col_reg) + NW'(1);
    assign r_p1   = NW'(row_reg) + NW'(1);
    assign d_p1   = NW'(chan_reg) + NW'(1);

    assign full_rows = r_p1 >= NW'(kernel_reg);
    assign emit      = full_rows && (rphase_reg == 4'd0) &&
                       (c_p1 >= NW'(kernel_reg)) && (cphase_reg == 4'd0);
    // last channel, window row and column: no further window fits past this one
    assign is_last   = (d_p1 == NW'(depth_reg)) &&
                       (NW'(row_reg) + NW'(stride_reg) >= NW'(height_reg)) &&
                       (NW'(col_reg) + NW'(stride_reg) >= NW'(width_reg));

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        chan_next   = chan_reg;
        wline_next  = wline_reg;
        cphase_next = cphase_reg;
        rphase_next = rphase_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            chan_next   = '0;
            wline_next  = '0;
            cphase_next = '0;
            rphase_next = '0;
            ocol_next   = '0;
            orow_next   = '0;
        end
        else if (take)
        begin
            if (c_p1 >= NW'(width_reg))
            begin
                // row done
                col_next    = '0;
                cphase_next = '0;
                ocol_next   = '0;
                if (full_rows)
                begin
                    if (rphase_reg == stride_reg - 4'd1)
                    begin
                        rphase_next = '0;
                        orow_next   = orow_reg + RW'(1);
                    end
                    else
                    begin
                        rphase_next = rphase_reg + 4'd1;
                    end
                end
                wline_next = (wline_reg == LW'(LINES - 1)) ? '0 : wline_reg + LW'(1);
                if (r_p1 >= NW'(height_reg))
                begin
                    // channel done
                    row_next    = '0;
                    rphase_next = '0;
                    orow_next   = '0;
                    wline_next  = '0;
                    chan_next   = (d_p1 >= NW'(depth_reg)) ? '0 : DCW'(d_p1);
                end
                else
                begin
                    row_next = RW'(r_p1);
                end
            end
            else
            begin
                col_next = CW'(c_p1);
                if (c_p1 >= NW'(kernel_reg))
                begin
                    if (cphase_reg == stride_reg - 4'd1)
                    begin
                        cphase_next = '0;
                        ocol_next   = ocol_reg + CW'(1);
                    end
                    else
                    begin
                        cphase_next = cphase_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            chan_reg   <= '0;
            wline_reg  <= '0;
            cphase_reg <= '0;
            rphase_reg <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            chan_reg   <= chan_next;
            wline_reg  <= wline_next;
            cphase_reg <= cphase_next;
            rphase_reg <= rphase_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    // item held while its column sum and average are formed
    logic signed [15:0] x_reg;
    logic [LW-1:0]      it_wline_reg;
    logic               it_full_reg, it_emit_reg, it_last_reg;
    logic [DCW-1:0]     it_chan_reg;
    logic [RW-1:0]      it_row_reg;
    logic [CW-1:0]      it_col_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg        <= samples.sample;
            it_wline_reg <= wline_reg;
            it_full_reg  <= full_rows;
            it_emit_reg  <= emit;
            it_last_reg  <= is_last;
            it_chan_reg  <= chan_reg;
            it_row_reg   <= orow_reg;
            it_col_reg   <= ocol_reg;
        end
    end

    // line stores: one RAM per line, all read at the sample's column
    logic signed [15:0] line_q [LINES];

    for (genvar i = 0; i < LINES; i++)
    begin : g_line
        apf_ram #(
            .WIDTH (16),
            .DEPTH (W_MAX)
        ) u_line (
            .clk     (clk),
            .wr_en   (take && (wline_reg == LW'(i))),
            .wr_addr (col_reg),
            .wr_data (samples.sample),
            .rd_en   (take),
            .rd_addr (col_reg),
            .rd_data (line_q[i])
        );
    end

    // column sum over the last kernel rows
    logic signed [CSW-1:0] colsum;

    always_comb
    begin
        colsum = CSW'(x_reg);
        for (int j = 1; j <= LINES; j++)
        begin
            logic [LW:0] idx;
            idx = (LW+1)'(it_wline_reg) + (LW+1)'(LINES - j);
            if (idx >= (LW+1)'(LINES))
            begin
                idx = idx - (LW+1)'(LINES);
            end
            if (5'(j) < {1'b0, kernel_reg})
            begin
                colsum = colsum + CSW'(line_q[idx[LW-1:0]]);
            end
        end
        if (!it_full_reg)
        begin
            colsum = '0;
        end
    end

    // chain of column-sum cells; the window sum ripples along the chain
    apf_pkg::cell_ctrl_t   cell_ctrl;
    logic signed [CSW-1:0] csum [K_MAX+1];
    logic signed [WSW-1:0] part [K_MAX+1];

    assign cell_ctrl.shift = (state_reg == apf_pkg::S_COL);
    assign cell_ctrl.clear = restart;
    assign csum[0] = colsum;
    assign part[0] = '0;

    for (genvar j = 0; j < K_MAX; j++)
    begin : g_cell
        apf_cell #(
            .CSW (CSW),
            .WSW (WSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .active   (5'(j) < {1'b0, kernel_reg}),
            .sum_in   (csum[j]),
            .sum_out  (csum[j+1]),
            .part_in  (part[j]),
            .part_out (part[j+1])
        );
    end

    // division by kernel squared
    logic               div_start, div_done;
    logic signed [15:0] div_q;
    logic [7:0]         ksq;

    assign ksq       = 8'(kernel_reg * kernel_reg);
    assign div_start = (state_reg == apf_pkg::S_SUM);

    apf_div #(
        .WSW (WSW),
        .DVW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (part[K_MAX]),
        .divisor  (DVW'(ksq)),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer and output register
    logic out_valid_reg, out_valid_next;
    logic load;

    assign load = (state_reg == apf_pkg::S_OUT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apf_pkg::S_IDLE: if (take) state_next = apf_pkg::S_COL;
            apf_pkg::S_COL:  state_next = it_emit_reg ? apf_pkg::S_SUM : apf_pkg::S_IDLE;
            apf_pkg::S_SUM:  state_next = apf_pkg::S_DIV;
            apf_pkg::S_DIV:  if (div_done) state_next = apf_pkg::S_OUT;
            apf_pkg::S_OUT:  if (load) state_next = apf_pkg::S_IDLE;
            default:         state_next = apf_pkg::S_IDLE;
        endcase
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apf_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    logic signed [15:0] avg_reg;
    logic [9:0]         och_reg, orw_reg, ocl_reg;
    logic               olast_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            avg_reg   <= div_q;
            och_reg   <= 10'(it_chan_reg);
            orw_reg   <= 10'(it_row_reg);
            ocl_reg   <= 10'(it_col_reg);
            olast_reg <= it_last_reg;
        end
    end

    assign samples.ready       = (state_reg == apf_pkg::S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.average     = avg_reg;
    assign results.out_channel = och_reg;
    assign results.out_row     = orw_reg;
    assign results.out_col     = ocl_reg;
    assign results.last        = olast_reg;

    // checks
    a_take_col: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == apf_pkg::S_COL)
        else $error("accepted sample did not start column sum");

    a_done_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == apf_pkg::S_DIV)
        else $error("divider finished outside divide state");

    a_wline: assert property (@(posedge clk) disable iff (!rst_n)
        wline_reg <= LW'(LINES - 1))
        else $error("line pointer out of range");

    a_cphase: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ok |-> (cphase_reg < stride_reg) && (rphase_reg < stride_reg))
        else $error("stride phase out of range");

    a_sum_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == apf_pkg::S_SUM |-> $past(state_reg) == apf_pkg::S_COL && it_emit_reg)
        else $error("window sum without a window");

endmodule
